// ----- rtl/core/dssd_pkg.sv -----
// Shared types, constants and the digit encoder for the seven-segment digit block.
package dssd_pkg;

	// Field widths.
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned POS_W      = 2;
	localparam int unsigned SEG_W      = 8;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned NUM_DIGITS = 4;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Division by ten as a multiply by a reciprocal; exact for all 16-bit values.
	localparam int unsigned     DIV10_MUL_W = 17;
	localparam logic [16:0]     DIV10_MUL   = 17'd52429;
	localparam int unsigned     DIV10_SHIFT = 19;
	localparam int unsigned     PROD_W      = VALUE_W + DIV10_MUL_W;
	localparam int unsigned     QUOT_W      = PROD_W - DIV10_SHIFT;

	// Place weights used for leading-zero blanking.
	localparam logic [VALUE_W-1:0] PLACE_TENS      = 16'd10;
	localparam logic [VALUE_W-1:0] PLACE_HUNDREDS  = 16'd100;
	localparam logic [VALUE_W-1:0] PLACE_THOUSANDS = 16'd1000;

	// Pattern of a blanked digit.
	localparam logic [SEG_W-1:0] BLANK_PATTERN = 8'h00;

	// One queued item: the value and a per-digit blank mask (bit k for the k-th word).
	typedef struct packed {
		logic [VALUE_W-1:0]    value;
		logic [NUM_DIGITS-1:0] blank;
	} dssd_item_t;

	// Seven-segment encoding, bit0 is segment a through bit6 segment g.
	function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] pat;
		unique case (digit)
			4'd0: pat = 8'h3F;
			4'd1: pat = 8'h06;
			4'd2: pat = 8'h5B;
			4'd3: pat = 8'h4F;
			4'd4: pat = 8'h66;
			4'd5: pat = 8'h6D;
			4'd6: pat = 8'h7D;
			4'd7: pat = 8'h07;
			4'd8: pat = 8'h7F;
			4'd9: pat = 8'h6F;
			default: pat = BLANK_PATTERN;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/core/dssd_front.sv -----
// Front stage: accepts a command word and works out which leading digits are blanked.
module dssd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [15:0]               value,
	input  logic                      zero_fill,
	output logic                      busy,
	input  logic                      queue_full,
	output logic                      push,
	output dssd_pkg::dssd_item_t      item
);
	import dssd_pkg::*;

	logic       valid_s1;
	dssd_item_t item_s1;
	dssd_item_t item_class;
	logic       take;

	// A held word that cannot move into the queue stalls the command port.
	assign busy = valid_s1 && queue_full;
	assign push = valid_s1 && !queue_full;
	assign take = start && !busy;
	assign item = item_s1;

	// Blank a leading digit when the value is below its place and zero-fill is off.
	always_comb begin
		item_class.value    = value;
		item_class.blank[0] = 1'b0;
		item_class.blank[1] = !zero_fill && (value < PLACE_TENS);
		item_class.blank[2] = !zero_fill && (value < PLACE_HUNDREDS);
		item_class.blank[3] = !zero_fill && (value < PLACE_THOUSANDS);
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_class;
		end
	end

endmodule

// ----- rtl/core/dssd_queue.sv -----
// Small first-in first-out queue of classified words between front and back.
module dssd_queue #(
	parameter int unsigned DEPTH = dssd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dssd_pkg::dssd_item_t item_in,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output dssd_pkg::dssd_item_t item_out
);
	import dssd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	dssd_item_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign item_out   = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

// ----- rtl/core/dssd_back.sv -----
// Back stage: peels one decimal digit per cycle and drives the result word.
module dssd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  dssd_pkg::dssd_item_t head_item,
	output logic                 pop,
	output logic                 strobe,
	output logic [1:0]           digit_position,
	output logic [7:0]           segment_pattern,
	output logic                 last_digit
);
	import dssd_pkg::*;

	localparam logic [POS_W-1:0] LAST_CNT = POS_W'(NUM_DIGITS - 1);

	logic                  active_q;
	logic [POS_W-1:0]      cnt_q;
	logic [VALUE_W-1:0]    rest_q;
	logic [NUM_DIGITS-1:0] blank_q;
	logic                  strobe_q;
	logic [POS_W-1:0]      pos_q;
	logic [SEG_W-1:0]      pattern_q;
	logic                  last_q;

	logic [PROD_W-1:0]     prod;
	logic [QUOT_W-1:0]     quot;
	logic [VALUE_W-1:0]    quot_x10;
	logic [VALUE_W-1:0]    digit_wide;
	logic [DIGIT_W-1:0]    digit;
	logic                  done_digit;

	// Quotient and remainder by ten of the remaining value.
	assign prod       = PROD_W'(rest_q) * PROD_W'(DIV10_MUL);
	assign quot       = prod[PROD_W-1:DIV10_SHIFT];
	assign quot_x10   = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
	assign digit_wide = rest_q - quot_x10;
	assign digit      = digit_wide[DIGIT_W-1:0];

	// Take the next word as the last digit of the current one goes out.
	assign done_digit = active_q && (cnt_q == LAST_CNT);
	assign pop        = head_valid && (!active_q || done_digit);

	// Digit sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (done_digit) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Remaining value and blank mask.
	always_ff @(posedge clk) begin
		if (pop) begin
			rest_q  <= head_item.value;
			blank_q <= head_item.blank;
		end else if (active_q) begin
			rest_q <= VALUE_W'(quot);
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		pos_q     <= LAST_CNT - cnt_q;
		pattern_q <= blank_q[cnt_q] ? BLANK_PATTERN : seg_encode(digit);
		last_q    <= (cnt_q == LAST_CNT);
	end

	assign strobe          = strobe_q;
	assign digit_position  = pos_q;
	assign segment_pattern = pattern_q;
	assign last_digit      = last_q;

endmodule

// ----- rtl/core/decimal_to_seven_segment_digits_top.sv -----
// Four-digit decimal to seven-segment encoder, top level.
// A command taken passes the front stage register, the queue and the back stage sequencer
// before the result word register sends its words, one per cycle, units first; the queue
// holds a command while the back stage is busy. The back stage emits one digit per cycle,
// and a queue of two words by default lets the front take commands while digits are sent.
// Reset clears the queue and both stages; the receiver cannot stall the result port.
module decimal_to_seven_segment_digits_top #(
	parameter int unsigned QUEUE_DEPTH = dssd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	input  logic        zero_fill,
	output logic        strobe,
	output logic [1:0]  digit_position,
	output logic [7:0]  segment_pattern,
	output logic        last_digit
);
	import dssd_pkg::*;

	logic       queue_full;
	logic       push;
	logic       pop;
	logic       head_valid;
	dssd_item_t front_item;
	dssd_item_t head_item;

	// Command intake and blanking classification.
	dssd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.zero_fill  (zero_fill),
		.busy       (busy),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	// Decoupling queue.
	dssd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item_in    (front_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.item_out   (head_item)
	);

	// Digit extraction and result output.
	dssd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_item       (head_item),
		.pop             (pop),
		.strobe          (strobe),
		.digit_position  (digit_position),
		.segment_pattern (segment_pattern),
		.last_digit      (last_digit)
	);

endmodule

// ----- rtl/core/dssd_checker.sv -----
// Port-level checks on the result sequence of the seven-segment digit block.
module dssd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        strobe,
	input logic [1:0]  digit_position,
	input logic [7:0]  segment_pattern,
	input logic        last_digit
);

	// The last word of a command is always the thousands position.
	a_last_is_thousands: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_digit |-> digit_position == 2'd0)
		else $error("last word is not at position 0");

	// Positions of one command come out back to back, counting down.
	a_positions_descend: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && digit_position != 2'd0 |=>
		strobe && digit_position == $past(digit_position) - 2'd1)
		else $error("digit sequence broken");

	// A burst of words after a gap always begins with the units digit.
	a_burst_starts_units: assert property (@(posedge clk) disable iff (!arst_n)
		!strobe |=> !strobe || digit_position == 2'd3)
		else $error("burst does not start at units");

	// The units digit is never blanked and the dot is never lit.
	a_units_shown: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && digit_position == 2'd3 |-> segment_pattern != 8'h00)
		else $error("units digit blanked");

	a_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !segment_pattern[7])
		else $error("dot segment set");

endmodule

bind decimal_to_seven_segment_digits_top dssd_checker u_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench for the four-digit decimal to seven-segment encoder.
`timescale 1ns / 100ps

module tb_top;

	import dssd_pkg::*;

	// One digit word as the block sends it.
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [SEG_W-1:0] seg;
		logic             last;
	} digit_word_t;

	// One command waiting to be sent.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               fill;
	} display_cmd_t;

	// Segment patterns for digits 0 to 9, digit 0 in the low byte.
	localparam logic [79:0] SEG_LUT = {
		8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [VALUE_W-1:0] value = '0;
	logic               zero_fill = 1'b0;
	logic               strobe;
	logic [POS_W-1:0]   digit_position;
	logic [SEG_W-1:0]   segment_pattern;
	logic               last_digit;

	display_cmd_t commands_pending[$];
	digit_word_t  digit_words_due[$];
	int unsigned  idle_pct = 0;
	int unsigned  errors = 0;
	int unsigned  commands_taken = 0;
	int unsigned  words_checked = 0;
	int unsigned  blank_words = 0;

	decimal_to_seven_segment_digits_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.zero_fill       (zero_fill),
		.strobe          (strobe),
		.digit_position  (digit_position),
		.segment_pattern (segment_pattern),
		.last_digit      (last_digit)
	);

	always #6 clk = ~clk;

	// Work out the four digit words a command must produce, units first.
	task automatic push_digit_words(input logic [VALUE_W-1:0] val, input logic fill);
		int unsigned rest;
		int unsigned dig;
		int unsigned weight;
		digit_word_t w;
		rest = val;
		weight = 1;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			dig = rest % 10;
			rest = rest / 10;
			w.pos = POS_W'(3 - k);
			w.seg = SEG_LUT[dig*8 +: 8];
			w.last = (k == NUM_DIGITS - 1);
			// A leading zero is blanked only when the value is below its place.
			if (k > 0 && !fill && dig == 0 && val < weight)
				w.seg = BLANK_PATTERN;
			digit_words_due.push_back(w);
			weight = weight * 10;
		end
	endtask

	// Wait until every command has been sent and every digit word has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (commands_pending.size() != 0 || start || digit_words_due.size() != 0);
	endtask

	// Driver: record the accepted command, then offer the next one or idle.
	always @(posedge clk) begin : drive
		display_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				push_digit_words(value, zero_fill);
				commands_taken++;
			end
			if (start && busy) begin
				// Hold the command until the block takes it.
			end else if (commands_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = commands_pending.pop_front();
				value <= nxt.value;
				zero_fill <= nxt.fill;
				start <= 1'b1;
			end else begin
				// Idle cycle: the inputs carry noise that must be ignored.
				start <= 1'b0;
				value <= VALUE_W'($urandom);
				zero_fill <= 1'($urandom_range(1));
			end
		end
	end

	// Monitor: compare each digit word with the oldest one expected.
	always @(posedge clk) begin : watch
		digit_word_t want;
		if (arst_n && strobe) begin
			if (digit_words_due.size() == 0) begin
				$error("unexpected digit word: position %0d pattern %h last %b",
					digit_position, segment_pattern, last_digit);
				errors++;
			end else begin
				want = digit_words_due.pop_front();
				if (digit_position !== want.pos) begin
					$error("digit_position: expected %0d, got %0d", want.pos, digit_position);
					errors++;
				end
				if (segment_pattern !== want.seg) begin
					$error("segment_pattern: expected %h, got %h", want.seg, segment_pattern);
					errors++;
				end
				if (last_digit !== want.last) begin
					$error("last_digit: expected %b, got %b", want.last, last_digit);
					errors++;
				end
				words_checked++;
				if (want.seg == BLANK_PATTERN)
					blank_words++;
			end
		end
	end

	// Stimulus: corner values first, then three random phases of differing pace.
	initial begin : stimulus
		int unsigned corner_values [12];
		int unsigned pace [3];
		display_cmd_t c;
		corner_values = '{0, 7, 10, 99, 100, 105, 999, 1000, 1050, 9999, 10100, 65535};
		pace = '{14, 74, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_pct = pace[0];
		foreach (corner_values[i]) begin
			c.value = VALUE_W'(corner_values[i]);
			c.fill = 1'b0;
			commands_pending.push_back(c);
			c.fill = 1'b1;
			commands_pending.push_back(c);
		end
		// The sender holds off here until every digit word is back.
		wait_drained();

		foreach (pace[p]) begin
			idle_pct = pace[p];
			repeat (150) begin
				// Most values are small so that blanking is exercised often.
				case ($urandom_range(3))
					0: c.value = VALUE_W'($urandom_range(9));
					1: c.value = VALUE_W'($urandom_range(1099));
					2: c.value = VALUE_W'($urandom_range(10999));
					default: c.value = VALUE_W'($urandom_range(65535));
				endcase
				c.fill = 1'($urandom_range(1));
				commands_pending.push_back(c);
			end
			wait_drained();
		end

		// Let any stray word show up after the last one expected.
		repeat (10) @(posedge clk);
		if (digit_words_due.size() != 0) begin
			$error("%0d digit words never arrived", digit_words_due.size());
			errors++;
		end
		$display("Summary: %0d commands over three pacing phases, %0d digit words checked,",
			commands_taken, words_checked);
		$display("Summary: %0d of them blanked leading zeros, %0d errors", blank_words, errors);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog against a hung handshake or missing words.
	initial begin : watchdog
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
